[hw/rtl/rms_voice_gate_with_hold_top_macros.svh]
// Assertion macros shared by the gate's checker
`ifndef RMS_VOICE_GATE_WITH_HOLD_TOP_MACROS_SVH
`define RMS_VOICE_GATE_WITH_HOLD_TOP_MACROS_SVH

// Same-cycle implication, off while reset is held
`define RVG_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held
`define RVG_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ant) |=> (cons)) else $error(msg);

`endif

[hw/rtl/rvg_pkg.sv]
// Shared types and constants of the RMS voice gate
`timescale 1ns / 1ps
`default_nettype none

package rvg_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_GATE_LEVEL   = 2'd0;
    localparam logic [1:0] REG_BLOCK_LENGTH = 2'd1;
    localparam logic [1:0] REG_HOLD_COUNT   = 2'd2;

    // Reset values of the registers
    localparam logic [15:0] GATE_LEVEL_RST   = 16'd1000;
    localparam logic [10:0] BLOCK_LENGTH_RST = 11'd512;
    localparam logic [7:0]  HOLD_COUNT_RST   = 8'd16;

    // Block length limits
    localparam int MAX_BLOCK_DEF = 1024;
    localparam int MIN_BLOCK     = 64;

    // Fixed widths
    localparam int SAMPLE_W  = 16;
    localparam int SQ_W      = 31;   // square of a 16-bit sample, up to 2^30
    localparam int RMS_W     = 16;
    localparam int SQ_RAD_W  = 32;   // radicand width, two bits per root step
    localparam int SQ_STEPS  = SQ_RAD_W / 2;
    localparam int SQ_REM_W  = RMS_W + 2;
    localparam int Q_DEPTH   = 2;

    // Action codes
    localparam logic [2:0] ACT_PREROLL  = 3'd0;
    localparam logic [2:0] ACT_DISCARD  = 3'd1;
    localparam logic [2:0] ACT_START    = 3'd2;
    localparam logic [2:0] ACT_CONTINUE = 3'd3;
    localparam logic [2:0] ACT_HANGOVER = 3'd4;
    localparam logic [2:0] ACT_STOP     = 3'd5;

    // One result word
    typedef struct packed {
        logic [RMS_W-1:0] rms;
        logic             loud;
        logic [2:0]       action;
        logic             recording;
    } t_res;

endpackage

`default_nettype wire

[hw/rtl/rvg_queue.sv]
// Small first-in first-out queue of words
`timescale 1ns / 1ps
`default_nettype none

module rvg_queue
    import rvg_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = Q_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rvg_front.sv]
// Front end: squares samples and sums them over one analysis block
`timescale 1ns / 1ps
`default_nettype none

module rvg_front
    import rvg_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF,
    parameter int CNT_W     = $clog2(MAX_BLOCK + 1),
    parameter int SUM_W     = SQ_W - 1 + CNT_W
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    output logic                            o_full,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic [10:0]                i_block_length,
    input  wire logic                       i_q_full,
    output logic                            o_q_push,
    output logic [SUM_W-1:0]                o_q_sum,
    output logic [CNT_W-1:0]                o_q_len
);

    logic                 r_sq_vld;
    logic [SQ_W-1:0]      r_sq;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]     w_len;
    logic signed [31:0]   w_prod;
    logic                 w_accept, w_adv, w_end;

    // A word waits in the square register while the block queue is full
    assign o_full   = r_sq_vld && i_q_full;
    assign w_accept = i_push && !o_full;
    assign w_adv    = r_sq_vld && !i_q_full;
    assign w_prod   = i_sample * i_sample;

    // Block length saturated to the supported range
    always_comb begin
        if (int'(i_block_length) < MIN_BLOCK) begin
            w_len = CNT_W'(MIN_BLOCK);
        end else if (int'(i_block_length) > MAX_BLOCK) begin
            w_len = CNT_W'(MAX_BLOCK);
        end else begin
            w_len = CNT_W'(i_block_length);
        end
    end

    // Square stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else if (w_accept) begin
            r_sq_vld <= 1'b1;
        end else if (w_adv) begin
            r_sq_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sq <= w_prod[SQ_W-1:0];
        end
    end

    // Accumulate; the block closes once the count reaches the length
    assign n_sum    = r_sum + SUM_W'(r_sq);
    assign n_cnt    = r_cnt + CNT_W'(1);
    assign w_end    = (n_cnt >= w_len);
    assign o_q_push = w_adv && w_end;
    assign o_q_sum  = n_sum;
    assign o_q_len  = w_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (w_adv) begin
            if (w_end) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rvg_back.sv]
// Back end: mean by division, integer square root, gate decision
`timescale 1ns / 1ps
`default_nettype none

module rvg_back
    import rvg_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF,
    parameter int CNT_W     = $clog2(MAX_BLOCK + 1),
    parameter int SUM_W     = SQ_W - 1 + CNT_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_blk_empty,
    output logic                  o_blk_pop,
    input  wire logic [SUM_W-1:0] i_blk_sum,
    input  wire logic [CNT_W-1:0] i_blk_len,
    input  wire logic [15:0]      i_gate_level,
    input  wire logic [7:0]       i_hold_count,
    input  wire logic             i_res_pop,
    output t_res                  o_res,
    output logic                  o_res_empty
);

    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]          r_state;
    logic [STEP_W-1:0]   r_step;
    logic [SUM_W-1:0]    r_num;
    logic [CNT_W-1:0]    r_den, r_rem;
    logic [CNT_W:0]      w_dtrial;
    logic                w_dge;
    logic [SQ_RAD_W-1:0] r_rad;
    logic [SQ_REM_W-1:0] r_srem, w_ssh, w_strial;
    logic [RMS_W-1:0]    r_root;
    logic                w_sge;
    logic                r_active;
    logic [7:0]          r_hold_cnt;
    logic                w_loud, w_hold_lt, n_active;
    logic [7:0]          n_hold_cnt;
    logic [2:0]          w_action;
    logic                w_res_full, w_res_push;
    t_res                w_res;
    logic [$bits(t_res)-1:0] w_res_bits;

    // Restoring division step: one quotient bit per cycle
    assign w_dtrial = {r_rem, r_num[SUM_W-1]};
    assign w_dge    = (w_dtrial >= {1'b0, r_den});

    // Square root step: two radicand bits per cycle
    assign w_ssh    = {r_srem[SQ_REM_W-3:0], r_rad[SQ_RAD_W-1 -: 2]};
    assign w_strial = {r_root, 2'b01};
    assign w_sge    = (w_ssh >= w_strial);

    // Gate decision
    assign w_loud    = (r_root > i_gate_level);
    assign w_hold_lt = (r_hold_cnt < i_hold_count);

    always_comb begin
        n_active   = r_active;
        n_hold_cnt = '0;
        if (w_loud) begin
            if (!r_active) begin
                if (w_hold_lt) begin
                    w_action   = ACT_PREROLL;
                    n_hold_cnt = r_hold_cnt + 8'd1;
                end else begin
                    w_action = ACT_START;
                    n_active = 1'b1;
                end
            end else begin
                w_action = ACT_CONTINUE;
            end
        end else begin
            if (r_active) begin
                if (w_hold_lt) begin
                    w_action   = ACT_HANGOVER;
                    n_hold_cnt = r_hold_cnt + 8'd1;
                end else begin
                    w_action = ACT_STOP;
                    n_active = 1'b0;
                end
            end else begin
                w_action = ACT_DISCARD;
            end
        end
    end

    assign w_res.rms       = r_root;
    assign w_res.loud      = w_loud;
    assign w_res.action    = w_action;
    assign w_res.recording = n_active;

    assign o_blk_pop  = (r_state == ST_IDLE) && !i_blk_empty;
    assign w_res_push = (r_state == ST_OUT) && !w_res_full;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_active   <= 1'b0;
            r_hold_cnt <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_blk_empty) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_step == '0) begin
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_step == '0) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!w_res_full) begin
                        r_state    <= ST_IDLE;
                        r_active   <= n_active;
                        r_hold_cnt <= n_hold_cnt;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath of the divider and the root unit
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_num  <= i_blk_sum;
                r_den  <= i_blk_len;
                r_rem  <= '0;
                r_step <= STEP_W'(SUM_W - 1);
            end
            ST_DIV: begin
                r_rem <= w_dge ? CNT_W'(w_dtrial - {1'b0, r_den})
                               : w_dtrial[CNT_W-1:0];
                r_num <= {r_num[SUM_W-2:0], w_dge};
                if (r_step == '0) begin
                    // quotient fits the radicand: a mean square is at most 2^30
                    r_rad  <= {r_num[SQ_RAD_W-2:0], w_dge};
                    r_srem <= '0;
                    r_root <= '0;
                    r_step <= STEP_W'(SQ_STEPS - 1);
                end else begin
                    r_step <= r_step - STEP_W'(1);
                end
            end
            ST_SQRT: begin
                r_srem <= w_sge ? (w_ssh - w_strial) : w_ssh;
                r_root <= {r_root[RMS_W-2:0], w_sge};
                r_rad  <= {r_rad[SQ_RAD_W-3:0], 2'b00};
                r_step <= r_step - STEP_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Result queue toward the output ports
    rvg_queue #(
        .W     ($bits(t_res)),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (i_res_pop),
        .o_data  (w_res_bits),
        .o_empty (o_res_empty)
    );

    assign o_res = t_res'(w_res_bits);

endmodule

`default_nettype wire

[hw/rtl/rms_voice_gate_with_hold_top.sv]
// Top level of the RMS voice gate with start and stop hold
// Takes one signed audio sample per cycle while full is low and sums its square
// into the current block. When a block of block_length samples closes (saturated
// to 64..MAX_BLOCK), its square sum goes to a two-word block queue, and the back
// end works out the integer rms: a restoring divider, then the root unit, then the
// gate decision, whose result word goes to the output queue. The back end is done
// with a block before the smallest block can close, so samples stream in at one
// per cycle; full rises only when the result queue and then the block queue have
// filled. The configuration port is always ready and writes take effect at once.
`timescale 1ns / 1ps
`default_nettype none

module rms_voice_gate_with_hold_top
    import rvg_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [RMS_W-1:0]                o_block_rms,
    output logic                            o_loud,
    output logic [2:0]                      o_action,
    output logic                            o_recording,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [15:0]                i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W = SQ_W - 1 + CNT_W;

    logic [15:0]       r_gate_level;
    logic [10:0]       r_block_length;
    logic [7:0]        r_hold_count;
    logic              w_q_push, w_q_full, w_q_empty, w_q_pop;
    logic [SUM_W-1:0]  w_q_sum_in, w_q_sum_out;
    logic [CNT_W-1:0]  w_q_len_in, w_q_len_out;
    t_res              w_res;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_level   <= GATE_LEVEL_RST;
            r_block_length <= BLOCK_LENGTH_RST;
            r_hold_count   <= HOLD_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_GATE_LEVEL:   r_gate_level   <= i_cfg_data;
                REG_BLOCK_LENGTH: r_block_length <= i_cfg_data[10:0];
                REG_HOLD_COUNT:   r_hold_count   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Accumulating front end
    rvg_front #(
        .MAX_BLOCK (MAX_BLOCK),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_sample       (i_sample),
        .i_block_length (r_block_length),
        .i_q_full       (w_q_full),
        .o_q_push       (w_q_push),
        .o_q_sum        (w_q_sum_in),
        .o_q_len        (w_q_len_in)
    );

    // Queue of finished block sums
    rvg_queue #(
        .W     (SUM_W + CNT_W),
        .DEPTH (Q_DEPTH)
    ) u_blk_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  ({w_q_sum_in, w_q_len_in}),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  ({w_q_sum_out, w_q_len_out}),
        .o_empty (w_q_empty)
    );

    // Divide, root and decide
    rvg_back #(
        .MAX_BLOCK (MAX_BLOCK),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_blk_empty  (w_q_empty),
        .o_blk_pop    (w_q_pop),
        .i_blk_sum    (w_q_sum_out),
        .i_blk_len    (w_q_len_out),
        .i_gate_level (r_gate_level),
        .i_hold_count (r_hold_count),
        .i_res_pop    (pop),
        .o_res        (w_res),
        .o_res_empty  (empty)
    );

    assign o_block_rms = w_res.rms;
    assign o_loud      = w_res.loud;
    assign o_action    = w_res.action;
    assign o_recording = w_res.recording;

endmodule

`default_nettype wire

[hw/rtl/rvg_checker.sv]
// Port-level checks of the RMS voice gate, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "rms_voice_gate_with_hold_top_macros.svh"

module rvg_checker
    import rvg_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       push,
    input wire logic                       full,
    input wire logic signed [SAMPLE_W-1:0] i_sample,
    input wire logic                       empty,
    input wire logic                       pop,
    input wire logic [RMS_W-1:0]           o_block_rms,
    input wire logic                       o_loud,
    input wire logic [2:0]                 o_action,
    input wire logic                       o_recording,
    input wire logic                       i_cfg_valid,
    input wire logic                       o_cfg_ready,
    input wire logic [1:0]                 i_cfg_index,
    input wire logic [15:0]                i_cfg_data
);

    // Recording after the block follows from the action taken
    `RVG_ASSERT_NOW(a_rec_matches_action, !empty, o_recording == (o_action == ACT_START || o_action == ACT_CONTINUE || o_action == ACT_HANGOVER), "recording flag disagrees with action")

    // Loud blocks only preroll, start or continue
    `RVG_ASSERT_NOW(a_loud_matches_action, !empty, o_loud == (o_action == ACT_PREROLL || o_action == ACT_START || o_action == ACT_CONTINUE), "loud flag disagrees with action")

    // A waiting result word holds until it is taken
    `RVG_ASSERT_NEXT(a_res_holds, !empty && !pop, !empty && $stable(o_block_rms) && $stable(o_action) && $stable(o_loud) && $stable(o_recording), "result word changed before pop")

endmodule

bind rms_voice_gate_with_hold_top rvg_checker u_rvg_checker (.*);

`default_nettype wire
